@@ rtl/ecss_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the eviction candidate score and select core
// no dependencies

package ecss_pkg;

    localparam logic [31:0] FAILURE_CAP_RESET = 32'hFFFF_FFFF;
    localparam logic [63:0] SAT_MAX           = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_MIN           = 64'h8000_0000_0000_0000;
    localparam logic [31:0] PRIO_MAX          = 32'h7FFF_FFFF;
    localparam logic [31:0] PRIO_MIN          = 32'h8000_0000;
    localparam logic [54:0] TOKEN_LIMIT       = '1;
    localparam logic [52:0] HINT_LIMIT        = '1;
    localparam logic [19:0] FAIL_WEIGHT       = 20'd1000000;
    localparam logic [26:0] DIV1000_MAGIC     = 27'd68719477;
    localparam logic [25:0] DIV1000           = 26'd1000;
    localparam int          NUM_STAGES        = 6;

    typedef enum logic [3:0] {
        EXCL_NONE       = 4'd0,
        EXCL_ACTIVE     = 4'd1,
        EXCL_PROTECTED  = 4'd2,
        EXCL_SHARED     = 4'd3,
        EXCL_WRITE_OPEN = 4'd4,
        EXCL_FAIL_STOP  = 4'd5,
        EXCL_EXHAUSTED  = 4'd6,
        EXCL_EPOCH      = 4'd7,
        EXCL_EMPTY      = 4'd8
    } excl_t;

    typedef struct packed {
        logic               fill;
        logic [31:0]        fail_count;
        logic [63:0]        io_cost;
        logic [63:0]        prefix_hint_tokens;
        logic [63:0]        idle_us;
        logic [63:0]        kv_tokens;
        logic [63:0]        reclaim_bytes;
        logic [2:0]         eval_flags;
        logic [3:0]         cand_flags;
        logic [63:0]        live_epoch;
        logic [63:0]        cand_epoch;
        logic signed [31:0] cand_id;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         fill;
        logic [31:0]        chosen_priority;
        logic [31:0]        chosen_id;
        logic               found;
        logic [63:0]        total;
        logic               eligible;
        logic [3:0]         exclusion;
    } out_beat_t;

    typedef struct packed {
        logic signed [31:0] cand_id;
        logic               final_item;
        excl_t              exclusion;
        logic [63:0]        tok_term;
        logic [63:0]        recl_term;
        logic [63:0]        hint_term;
        logic [63:0]        io_term;
        logic [51:0]        fail_term;
        logic [63:0]        pos_sum;
        logic [64:0]        neg_sum;
        logic [63:0]        idle_work;
        logic [9:0]         idle_rem;
        logic [63:0]        total;
    } pipe_t;

    typedef struct packed {
        logic [15:0] q;
        logic [9:0]  r;
    } div_step_t;

    // one 16-bit digit of a long division by 1000
    function automatic div_step_t div1000_step(input logic [9:0] rem, input logic [15:0] chunk);
        logic [25:0] x;
        logic [52:0] prod;
        logic [25:0] back;
        div_step_t   res;
        x     = {rem, chunk};
        prod  = {27'd0, x} * {26'd0, DIV1000_MAGIC};
        res.q = prod[51:36];
        back  = {10'd0, res.q} * DIV1000;
        res.r = 10'(x - back);
        return res;
    endfunction

endpackage

@@ rtl/evict_candidate_score_select_core.sv @@
`timescale 1ns / 1ps
// eviction candidate scoring and best-candidate selection core
// depends on ecss_pkg
//
// usage:
//   one candidate per s_axis beat, s_axis_tlast marks the last candidate of a scan
//   one result beat per candidate on m_axis, m_axis_tlast set on the scan result
//   the scan result carries found, chosen id and its priority clamped to int32
//   cfg_we/cfg_wdata write failure_cap, only while no beat is in flight
// pipeline: an accepted input beat passes the input register, five internal stages and
//   the output register on the way to its result beat; the idle-age divide by 1000 takes
//   four of the stages, one 16-bit digit per stage
// throughput: one candidate per cycle while m_axis_tready does not stall the result
// reset: all stages empty, no best candidate held, failure_cap all ones
// stall: when m_axis_tready is low the result holds, earlier stages keep
//   filling until every stage is full, then s_axis_tready drops

module evict_candidate_score_select_core
    import ecss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cand_id, cand_epoch, live_epoch, cand_flags, eval_flags, reclaim_bytes,
    // kv_tokens, idle_us, prefix_hint_tokens, io_cost, fail_count, zero fill
    input  logic [519:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // exclusion, eligible, total, found, chosen_id, chosen_priority, zero fill
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast
);

    logic [31:0]             cap_reg;
    logic [NUM_STAGES-1:0]   vld_reg;
    logic [NUM_STAGES-1:0]   en;
    logic                    out_en;
    in_beat_t                in_reg;
    logic                    in_last_reg;
    pipe_t                   pipe_reg [1:NUM_STAGES-1];
    pipe_t                   pipe_next [1:NUM_STAGES-1];
    logic                    out_vld_reg;
    out_beat_t               out_reg;
    out_beat_t               out_next;
    logic                    out_last_reg;
    logic                    best_valid_reg;
    logic                    best_valid_next;
    logic signed [31:0]      best_id_reg;
    logic signed [31:0]      best_id_next;
    logic signed [63:0]      best_total_reg;
    logic signed [63:0]      best_total_next;

    // stage enables
    always_comb
    begin
        out_en = !out_vld_reg || m_axis_tready;
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_en;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_axis_tready = en[0];

    // exclusion, terms and first digit of the idle divide
    always_comb
    begin
        logic [31:0] fails_cl;
        div_step_t   st;
        excl_t       ex;
        pipe_t       p;
        fails_cl = (in_reg.fail_count > cap_reg) ? cap_reg : in_reg.fail_count;
        if (in_reg.eval_flags[0])
            ex = EXCL_WRITE_OPEN;
        else if (in_reg.eval_flags[1] || in_reg.eval_flags[2])
            ex = EXCL_FAIL_STOP;
        else if (in_reg.cand_epoch != in_reg.live_epoch)
            ex = EXCL_EPOCH;
        else if (in_reg.cand_flags[3])
            ex = EXCL_EXHAUSTED;
        else if (in_reg.cand_flags[0])
            ex = EXCL_ACTIVE;
        else if (in_reg.cand_flags[1])
            ex = EXCL_PROTECTED;
        else if (in_reg.cand_flags[2])
            ex = EXCL_SHARED;
        else if (in_reg.cand_id < 0 || in_reg.reclaim_bytes == '0 || in_reg.kv_tokens == '0)
            ex = EXCL_EMPTY;
        else
            ex = EXCL_NONE;
        st = div1000_step(10'd0, in_reg.idle_us[63:48]);
        p = '0;
        p.cand_id    = in_reg.cand_id;
        p.final_item = in_last_reg;
        p.exclusion  = ex;
        p.tok_term   = (in_reg.kv_tokens > {9'd0, TOKEN_LIMIT})
                       ? {1'b0, TOKEN_LIMIT, 8'd0} : {1'b0, in_reg.kv_tokens[54:0], 8'd0};
        p.recl_term  = {3'd0, in_reg.reclaim_bytes[63:12], 9'd0};
        p.hint_term  = (in_reg.prefix_hint_tokens > {11'd0, HINT_LIMIT})
                       ? {1'b0, HINT_LIMIT, 10'd0}
                       : {1'b0, in_reg.prefix_hint_tokens[52:0], 10'd0};
        p.io_term    = {6'd0, in_reg.io_cost[63:12], 6'd0};
        p.fail_term  = {20'd0, fails_cl} * {32'd0, FAIL_WEIGHT};
        p.idle_work  = {in_reg.idle_us[47:0], st.q};
        p.idle_rem   = st.r;
        pipe_next[1] = p;
    end

    // partial sums and remaining divide digits
    always_comb
    begin
        div_step_t st2;
        div_step_t st3;
        div_step_t st4;
        pipe_t     p2;
        pipe_t     p3;
        pipe_t     p4;
        p2 = pipe_reg[1];
        st2 = div1000_step(p2.idle_rem, p2.idle_work[63:48]);
        p2.pos_sum   = p2.tok_term + p2.recl_term;
        p2.neg_sum   = {1'b0, p2.hint_term} + {1'b0, p2.io_term} + {13'd0, p2.fail_term};
        p2.idle_work = {p2.idle_work[47:0], st2.q};
        p2.idle_rem  = st2.r;
        pipe_next[2] = p2;

        p3 = pipe_reg[2];
        st3 = div1000_step(p3.idle_rem, p3.idle_work[63:48]);
        p3.idle_work = {p3.idle_work[47:0], st3.q};
        p3.idle_rem  = st3.r;
        pipe_next[3] = p3;

        p4 = pipe_reg[3];
        st4 = div1000_step(p4.idle_rem, p4.idle_work[63:48]);
        p4.idle_work = {p4.idle_work[47:0], st4.q};
        p4.idle_rem  = st4.r;
        pipe_next[4] = p4;
    end

    // saturated total
    always_comb
    begin
        logic [63:0]        idle_term;
        logic [64:0]        pos_all;
        logic [63:0]        psat;
        logic signed [65:0] diff;
        pipe_t              p5;
        p5 = pipe_reg[4];
        idle_term = {p5.idle_work[61:0], 2'b00};
        pos_all   = {1'b0, idle_term} + {1'b0, p5.pos_sum};
        psat      = (pos_all > {1'b0, SAT_MAX}) ? SAT_MAX : pos_all[63:0];
        diff      = $signed({2'b00, psat}) - $signed({1'b0, p5.neg_sum});
        if (p5.exclusion != EXCL_NONE)
            p5.total = '0;
        else if (diff[65:63] == 3'b000 || diff[65:63] == 3'b111)
            p5.total = diff[63:0];
        else
            p5.total = SAT_MIN;
        pipe_next[5] = p5;
    end

    // best candidate tracking and result beat
    always_comb
    begin
        pipe_t              p;
        logic               elig;
        logic               take;
        logic signed [63:0] tot;
        p    = pipe_reg[NUM_STAGES-1];
        tot  = $signed(p.total);
        elig = (p.exclusion == EXCL_NONE);
        take = elig && (!best_valid_reg || tot > best_total_reg
                        || (tot == best_total_reg && p.cand_id < best_id_reg));
        best_valid_next = best_valid_reg || take;
        best_id_next    = take ? p.cand_id : best_id_reg;
        best_total_next = take ? tot : best_total_reg;
        out_next = '0;
        out_next.exclusion = p.exclusion;
        out_next.eligible  = elig;
        out_next.total     = p.total;
        if (p.final_item && best_valid_next)
        begin
            out_next.found     = 1'b1;
            out_next.chosen_id = best_id_next;
            if (best_total_next[63:31] == '0 || best_total_next[63:31] == '1)
                out_next.chosen_priority = best_total_next[31:0];
            else if (best_total_next[63])
                out_next.chosen_priority = PRIO_MIN;
            else
                out_next.chosen_priority = PRIO_MAX;
        end
        if (p.final_item)
            best_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= FAILURE_CAP_RESET;
            vld_reg        <= '0;
            out_vld_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            best_id_reg    <= '0;
            best_total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (en[0])
                vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
            if (out_en)
                out_vld_reg <= vld_reg[NUM_STAGES-1];
            if (out_en && vld_reg[NUM_STAGES-1])
            begin
                best_valid_reg <= best_valid_next;
                best_id_reg    <= best_id_next;
                best_total_reg <= best_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            in_reg      <= in_beat_t'(s_axis_tdata);
            in_last_reg <= s_axis_tlast;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (en[i])
                pipe_reg[i] <= pipe_next[i];
        end
        if (out_en)
        begin
            out_reg      <= out_next;
            out_last_reg <= pipe_reg[NUM_STAGES-1].final_item;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ rtl/ecss_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the eviction candidate score and select core
// depends on ecss_pkg, bound to evict_candidate_score_select_core

module ecss_checker
    import ecss_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tlast
);

    out_beat_t ob;

    assign ob = out_beat_t'(m_axis_tdata);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed under stall");

    a_elig: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (ob.eligible == (ob.exclusion == EXCL_NONE)))
        else $error("eligible disagrees with exclusion");

    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !ob.eligible |-> ob.total == '0)
        else $error("excluded candidate with nonzero total");

    a_choice: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !(m_axis_tlast && ob.found) |->
            !ob.found && ob.chosen_id == '0 && ob.chosen_priority == '0)
        else $error("choice reported outside a found scan result");

endmodule

bind evict_candidate_score_select_core ecss_checker u_ecss_checker (.*);
